### hdl/vlms_pkg.sv
// ----------------------------------------------------------------------------
// vlms_pkg: shared types, constants and microprogram
// Codes, control word layout and the read-only control store of the value
// list sequencer.
// ----------------------------------------------------------------------------
package vlms_pkg;

  // field widths and defaults
  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int VAL_W     = 32;
  localparam int SUM_OUT_W = 36;
  localparam int CNT_OUT_W = 5;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int UPC_W     = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request modes
  localparam logic [MODE_W-1:0] MODE_INS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RM    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // result status
  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // datapath actions, one per control word
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_TAKE,
    ACT_INS,
    ACT_RM_INIT,
    ACT_STEP_DN,
    ACT_SCAN,
    ACT_NF,
    ACT_PTR_INC,
    ACT_SH_MOVE,
    ACT_RM_DEC,
    ACT_Q_INIT,
    ACT_STEP_UP,
    ACT_Q_FIRST,
    ACT_Q_ACC,
    ACT_Q_DONE,
    ACT_EMIT
  } act_t;

  // sequencer branch kinds
  typedef enum logic [2:0] {
    BR_NEXT,   // fall through
    BR_GOTO,   // jump always
    BR_REQ,    // dispatch on request, else hold
    BR_EMPTY,  // list empty: jump, else fall through
    BR_ENDN,   // pointer at end: jump, else fall through
    BR_ENDS,   // pointer at end: jump, else hold
    BR_SCAN,   // match: jump, first entry checked: fall through, else hold
    BR_OUT     // output register free: jump, else hold
  } br_t;

  typedef struct packed {
    act_t             act;
    br_t              br;
    logic [UPC_W-1:0] tgt;
  } uword_t;

  // status flags from the datapath
  typedef struct packed {
    logic cnt_zero;
    logic at_end;
    logic match;
    logic tag_zero;
  } dp_flags_t;

  // control store addresses
  localparam logic [UPC_W-1:0] U_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] U_INS      = 4'd1;
  localparam logic [UPC_W-1:0] U_RM_INIT  = 4'd2;
  localparam logic [UPC_W-1:0] U_RM_PRIME = 4'd3;
  localparam logic [UPC_W-1:0] U_RM_SCAN  = 4'd4;
  localparam logic [UPC_W-1:0] U_RM_NF    = 4'd5;
  localparam logic [UPC_W-1:0] U_SH_PRIME = 4'd6;
  localparam logic [UPC_W-1:0] U_SH_MOVE  = 4'd7;
  localparam logic [UPC_W-1:0] U_RM_DONE  = 4'd8;
  localparam logic [UPC_W-1:0] U_Q_INIT   = 4'd9;
  localparam logic [UPC_W-1:0] U_Q_PRIME  = 4'd10;
  localparam logic [UPC_W-1:0] U_Q_FIRST  = 4'd11;
  localparam logic [UPC_W-1:0] U_Q_LOOP   = 4'd12;
  localparam logic [UPC_W-1:0] U_Q_DONE   = 4'd13;
  localparam logic [UPC_W-1:0] U_EMIT     = 4'd14;

  // microprogram
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      U_IDLE:     w = '{ACT_TAKE,    BR_REQ,   U_IDLE};
      U_INS:      w = '{ACT_INS,     BR_GOTO,  U_EMIT};
      U_RM_INIT:  w = '{ACT_RM_INIT, BR_EMPTY, U_EMIT};
      U_RM_PRIME: w = '{ACT_STEP_DN, BR_NEXT,  U_IDLE};
      U_RM_SCAN:  w = '{ACT_SCAN,    BR_SCAN,  U_SH_PRIME};
      U_RM_NF:    w = '{ACT_NF,      BR_GOTO,  U_EMIT};
      U_SH_PRIME: w = '{ACT_PTR_INC, BR_ENDN,  U_RM_DONE};
      U_SH_MOVE:  w = '{ACT_SH_MOVE, BR_ENDS,  U_RM_DONE};
      U_RM_DONE:  w = '{ACT_RM_DEC,  BR_GOTO,  U_EMIT};
      U_Q_INIT:   w = '{ACT_Q_INIT,  BR_EMPTY, U_EMIT};
      U_Q_PRIME:  w = '{ACT_STEP_UP, BR_NEXT,  U_IDLE};
      U_Q_FIRST:  w = '{ACT_Q_FIRST, BR_ENDN,  U_Q_DONE};
      U_Q_LOOP:   w = '{ACT_Q_ACC,   BR_ENDS,  U_Q_DONE};
      U_Q_DONE:   w = '{ACT_Q_DONE,  BR_GOTO,  U_EMIT};
      U_EMIT:     w = '{ACT_EMIT,    BR_OUT,   U_IDLE};
      default:    w = '{ACT_NOP,     BR_GOTO,  U_IDLE};
    endcase
    return w;
  endfunction

  // entry point of each request mode
  function automatic logic [UPC_W-1:0] dispatch(input logic [MODE_W-1:0] mode);
    logic [UPC_W-1:0] a;
    unique case (mode)
      MODE_INS:   a = U_INS;
      MODE_RM:    a = U_RM_INIT;
      MODE_QUERY: a = U_Q_INIT;
      default:    a = U_EMIT;
    endcase
    return a;
  endfunction

endpackage

### hdl/vlms_seq.sv
// ----------------------------------------------------------------------------
// vlms_seq: microcode sequencer
// Step counter over the control store with conditional jumps and a dispatch
// on the request mode.
// ----------------------------------------------------------------------------
module vlms_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req,
  input  logic [vlms_pkg::MODE_W-1:0]    mode,
  input  logic                           out_free,
  input  vlms_pkg::dp_flags_t            flags,
  output vlms_pkg::uword_t               ctrl
);

  logic [vlms_pkg::UPC_W-1:0] upc_r;
  logic [vlms_pkg::UPC_W-1:0] upc_nxt;
  logic [vlms_pkg::UPC_W-1:0] upc_inc;

  // control word fetch
  assign ctrl    = vlms_pkg::ucode(upc_r);
  assign upc_inc = upc_r + vlms_pkg::UPC_W'(1);

  // next step select
  always_comb begin
    unique case (ctrl.br)
      vlms_pkg::BR_NEXT:  upc_nxt = upc_inc;
      vlms_pkg::BR_GOTO:  upc_nxt = ctrl.tgt;
      vlms_pkg::BR_REQ:   upc_nxt = req ? vlms_pkg::dispatch(mode) : upc_r;
      vlms_pkg::BR_EMPTY: upc_nxt = flags.cnt_zero ? ctrl.tgt : upc_inc;
      vlms_pkg::BR_ENDN:  upc_nxt = flags.at_end ? ctrl.tgt : upc_inc;
      vlms_pkg::BR_ENDS:  upc_nxt = flags.at_end ? ctrl.tgt : upc_r;
      vlms_pkg::BR_SCAN:  upc_nxt = flags.match ? ctrl.tgt :
                                    (flags.tag_zero ? upc_inc : upc_r);
      vlms_pkg::BR_OUT:   upc_nxt = out_free ? ctrl.tgt : upc_r;
      default:            upc_nxt = vlms_pkg::U_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= vlms_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### hdl/vlms_dp.sv
// ----------------------------------------------------------------------------
// vlms_dp: list datapath
// Entry memory with registered read, count, scan pointers and the run sum
// accumulator, driven by one action code per cycle.
// ----------------------------------------------------------------------------
module vlms_dp #(
  parameter int DEPTH = vlms_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic signed [vlms_pkg::VAL_W-1:0] in_value,
  input  logic [vlms_pkg::CAP_W-1:0]        capacity,
  input  vlms_pkg::act_t                    act,
  output vlms_pkg::dp_flags_t               flags,
  output vlms_pkg::status_t                 status,
  output logic signed [vlms_pkg::VAL_W+$clog2(DEPTH+1)-1:0] sum,
  output logic [$clog2(DEPTH+1)-1:0]        cnt
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = vlms_pkg::VAL_W + AW;
  localparam int CW = (AW > vlms_pkg::CAP_W) ? AW : vlms_pkg::CAP_W;

  logic signed [vlms_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [vlms_pkg::VAL_W-1:0] rd_data_r;
  logic signed [vlms_pkg::VAL_W-1:0] val_r;
  logic [AW-1:0]                     ptr_r;
  logic [AW-1:0]                     tag_r;
  logic [AW-1:0]                     cnt_r;
  logic signed [SW-1:0]              run_r;
  logic signed [SW-1:0]              best_r;
  logic signed [SW-1:0]              sum_r;
  vlms_pkg::status_t                 status_r;

  logic                              full;
  logic                              wr_en;
  logic [IW-1:0]                     wr_idx;
  logic signed [vlms_pkg::VAL_W-1:0] wr_data;
  logic signed [SW-1:0]              v_ext;
  logic signed [SW-1:0]              run_acc;
  logic                              run_pos;

  // capacity check, capacity above the depth acts as the depth
  assign full = (CW'(cnt_r) >= CW'(capacity)) || (cnt_r == AW'(DEPTH));

  // run sum step
  assign v_ext   = SW'(rd_data_r);
  assign run_pos = !run_r[SW-1] && (run_r != '0);
  assign run_acc = run_pos ? (run_r + v_ext) : v_ext;

  // status flags for the sequencer
  assign flags.cnt_zero = (cnt_r == '0);
  assign flags.at_end   = (ptr_r >= cnt_r);
  assign flags.match    = (rd_data_r == val_r);
  assign flags.tag_zero = (tag_r == '0);

  // memory write port: append or shift down
  assign wr_en   = ((act == vlms_pkg::ACT_INS) && !full) || (act == vlms_pkg::ACT_SH_MOVE);
  assign wr_idx  = (act == vlms_pkg::ACT_INS) ? cnt_r[IW-1:0] : tag_r[IW-1:0];
  assign wr_data = (act == vlms_pkg::ACT_INS) ? val_r : rd_data_r;

  // entry memory, read at the scan pointer every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[ptr_r[IW-1:0]];
  end

  // count and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
      tag_r <= '0;
    end else begin
      unique case (act)
        vlms_pkg::ACT_INS: begin
          if (!full) begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        vlms_pkg::ACT_RM_INIT: begin
          ptr_r <= cnt_r - AW'(1);
        end
        vlms_pkg::ACT_STEP_DN: begin
          tag_r <= ptr_r;
          ptr_r <= ptr_r - AW'(1);
        end
        vlms_pkg::ACT_SCAN: begin
          if (flags.match) begin
            ptr_r <= tag_r + AW'(1);
          end else begin
            tag_r <= ptr_r;
            ptr_r <= ptr_r - AW'(1);
          end
        end
        vlms_pkg::ACT_PTR_INC: begin
          ptr_r <= ptr_r + AW'(1);
        end
        vlms_pkg::ACT_SH_MOVE: begin
          tag_r <= tag_r + AW'(1);
          ptr_r <= ptr_r + AW'(1);
        end
        vlms_pkg::ACT_RM_DEC: begin
          cnt_r <= cnt_r - AW'(1);
        end
        vlms_pkg::ACT_Q_INIT: begin
          ptr_r <= '0;
        end
        vlms_pkg::ACT_STEP_UP, vlms_pkg::ACT_Q_FIRST, vlms_pkg::ACT_Q_ACC: begin
          tag_r <= ptr_r;
          ptr_r <= ptr_r + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // request value, status and run sum
  always_ff @(posedge clk) begin
    if (take) begin
      val_r    <= in_value;
      status_r <= vlms_pkg::ST_DONE;
      sum_r    <= '0;
    end
    unique case (act)
      vlms_pkg::ACT_INS: begin
        if (full) begin
          status_r <= vlms_pkg::ST_FULL;
        end
      end
      vlms_pkg::ACT_RM_INIT, vlms_pkg::ACT_Q_INIT: begin
        if (flags.cnt_zero) begin
          status_r <= vlms_pkg::ST_EMPTY;
        end
      end
      vlms_pkg::ACT_NF: begin
        status_r <= vlms_pkg::ST_NOTFOUND;
      end
      vlms_pkg::ACT_Q_FIRST: begin
        run_r  <= v_ext;
        best_r <= v_ext;
      end
      vlms_pkg::ACT_Q_ACC: begin
        run_r <= run_acc;
        if (run_acc > best_r) begin
          best_r <= run_acc;
        end
      end
      vlms_pkg::ACT_Q_DONE: begin
        sum_r <= best_r;
      end
      default: begin
      end
    endcase
  end

  assign status = status_r;
  assign sum    = sum_r;
  assign cnt    = cnt_r;

endmodule

### hdl/value_list_with_max_run_sum.sv
// ----------------------------------------------------------------------------
// value_list_with_max_run_sum: ordered value list with maximum run sum query
// Microcoded list of signed values: append, remove last match, best run sum.
// ----------------------------------------------------------------------------
// Insert and mode 3 pass straight to the emit step; a query walks every entry
//   and a remove scans down from the last entry, then shifts the rest down.
// One request at a time; the next is taken in the cycle after the result is
//   loaded, and remove and query walk the memory one entry per cycle.
// Reset clears the count and sequencer and sets capacity to 16; entries are
//   not cleared, since only written ones are read.
module value_list_with_max_run_sum #(
  parameter int DEPTH = vlms_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [vlms_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [vlms_pkg::VAL_W-1:0]     in_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [vlms_pkg::STAT_W-1:0]           out_status,
  output logic signed [vlms_pkg::SUM_OUT_W-1:0] out_max_sum,
  output logic [vlms_pkg::CNT_OUT_W-1:0]        out_entry_count,
  // capacity register write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vlms_pkg::CAP_W-1:0]            cfg_capacity
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int SW = vlms_pkg::VAL_W + AW;

  vlms_pkg::uword_t                    ctrl;
  vlms_pkg::dp_flags_t                 flags;
  vlms_pkg::status_t                   dp_status;
  logic signed [SW-1:0]                dp_sum;
  logic [AW-1:0]                       dp_cnt;
  logic [vlms_pkg::CAP_W-1:0]          cap_r;
  logic                                take;
  logic                                out_free;
  logic                                emit;

  logic                                out_valid_r;
  logic [vlms_pkg::STAT_W-1:0]         out_status_r;
  logic signed [vlms_pkg::SUM_OUT_W-1:0] out_sum_r;
  logic [vlms_pkg::CNT_OUT_W-1:0]      out_cnt_r;

  // handshakes
  assign in_ready  = (ctrl.act == vlms_pkg::ACT_TAKE);
  assign take      = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (ctrl.act == vlms_pkg::ACT_EMIT) && out_free;
  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= vlms_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_capacity;
    end
  end

  vlms_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (in_valid),
    .mode     (in_mode),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  vlms_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_value (in_value),
    .capacity (cap_r),
    .act      (ctrl.act),
    .flags    (flags),
    .status   (dp_status),
    .sum      (dp_sum),
    .cnt      (dp_cnt)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= dp_status;
      out_sum_r    <= vlms_pkg::SUM_OUT_W'(dp_sum);
      out_cnt_r    <= vlms_pkg::CNT_OUT_W'(dp_cnt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_max_sum     = out_sum_r;
  assign out_entry_count = out_cnt_r;

  // count never runs past the memory depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cnt <= AW'(DEPTH))
    else $error("entry count above depth");

  // a result appears only from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.act == vlms_pkg::ACT_EMIT))
    else $error("result loaded outside emit step");

  // no second request while one is in work
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ready)
    else $error("request accepted while busy");

  // a failed result carries a zero sum
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != vlms_pkg::ST_DONE) |-> (out_sum_r == '0))
    else $error("nonzero sum on failed request");

endmodule

### tb/value_list_with_max_run_sum_test.sv
// ----------------------------------------------------------------------------
// value_list_with_max_run_sum_test: self-checking bench for the value list
// Drives insert, remove, query and unused-mode requests through the request
// channel, predicts every result with an in-bench list model and checks
// status, run sum and entry count field by field, across several capacity
// settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module value_list_with_max_run_sum_test;
  import vlms_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEF;
  localparam int PHASE_ITEMS   = 144;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    int                      gap;
  } request_t;

  typedef struct {
    status_t                     status;
    logic signed [SUM_OUT_W-1:0] max_sum;
    logic [CNT_OUT_W-1:0]        entry_count;
  } list_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [MODE_W-1:0]           in_mode = MODE_NOP;
  logic signed [VAL_W-1:0]     in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [STAT_W-1:0]           out_status;
  logic signed [SUM_OUT_W-1:0] out_max_sum;
  logic [CNT_OUT_W-1:0]        out_entry_count;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CAP_W-1:0]            cfg_capacity = CAP_RESET;

  // handshakes seen at the last rising edge
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic cfg_taken = 1'b0;

  request_t     pending_requests[$];
  list_result_t expected_results[$];
  int           requests_posted = 0;
  int           requests_taken = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           send_wait = 0;
  bit           send_calm = 1'b0;
  int           rx_wait = 0;
  bit           rx_calm = 1'b0;
  int           holds_asked = 0;
  int           holds_done = 0;

  // list model state
  logic signed [VAL_W-1:0] list_vals[LIST_DEPTH];
  int                      list_len = 0;
  logic [CAP_W-1:0]        cap_reg = CAP_RESET;

  value_list_with_max_run_sum dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_max_sum     (out_max_sum),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity)
  );

  always #4 clk = ~clk;

  // apply one request to the list model and return its result
  function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] mode,
                                                 input logic signed [VAL_W-1:0] value);
    list_result_t r;
    int           eff_cap;
    int           pos;
    longint       best;
    longint       run;
    r.status  = ST_DONE;
    r.max_sum = '0;
    eff_cap   = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
    case (mode)
      MODE_INS: begin
        if (list_len >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          list_vals[list_len] = value;
          list_len++;
        end
      end
      MODE_RM: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // last matching entry wins
          pos = -1;
          for (int i = list_len - 1; i >= 0; i--)
            if (pos < 0 && list_vals[i] == value) pos = i;
          if (pos < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int i = pos; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
            list_len--;
          end
        end
      end
      MODE_QUERY: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // best non-empty run, first entry included
          best = list_vals[0];
          run  = best;
          for (int i = 1; i < list_len; i++) begin
            run = (run > 0) ? run + longint'(list_vals[i]) : longint'(list_vals[i]);
            if (run > best) best = run;
          end
          r.max_sum = best[SUM_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    r.entry_count = list_len[CNT_OUT_W-1:0];
    return r;
  endfunction

  // sample handshakes, check results, advance the list model
  always @(posedge clk) begin
    list_result_t want;
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_max_sum !== want.max_sum) begin
            $error("max_sum mismatch: expected %0d, actual %0d", want.max_sum, out_max_sum);
            mismatches++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.entry_count, out_entry_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_capacity;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_list_op(in_mode, in_value));
        requests_taken++;
      end
    end
  end

  // request driver, one queued request at a time with its own gap after it
  always @(negedge clk) begin
    request_t req;
    if (in_valid && !in_taken) begin
      // hold until taken
    end else if (send_wait > 0) begin
      in_valid  <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (rst_n && pending_requests.size() != 0) begin
      req = pending_requests.pop_front();
      in_valid  <= 1'b1;
      in_mode   <= req.mode;
      in_value  <= req.value;
      send_wait <= req.gap;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    int stall;
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait   <= rx_wait - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      out_ready  <= 1'b0;
      rx_wait    <= LONG_HOLD - 1;
    end else if (out_taken) begin
      if ($urandom_range(0, 63) == 0) rx_calm <= !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      out_ready <= (stall == 0);
      rx_wait   <= (stall == 0) ? 0 : stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // queue one request; gaps come in stretches with and without idling
  function automatic void post_request(input logic [MODE_W-1:0] mode,
                                       input logic signed [VAL_W-1:0] value);
    request_t req;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    req.mode  = mode;
    req.value = value;
    req.gap   = send_calm ? 0 : $urandom_range(0, 6);
    pending_requests.push_back(req);
    requests_posted++;
  endfunction

  // wait until every request is taken and answered, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_taken != requests_posted || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // value drawn for a phase's small pool, so removes find their targets
  function automatic logic signed [VAL_W-1:0] pool_value(input int style);
    logic signed [VAL_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = $urandom_range(0, 20) - 10;
    endcase
    return v;
  endfunction

  initial begin
    logic signed [VAL_W-1:0] pool[6];
    logic [CAP_W-1:0]        caps[12];
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    int                      style;
    int                      roll;
    caps = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd5, 5'd17, 5'd3, 5'd12, 5'd8, 5'd30, 5'd2, 5'd16};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list cases, fill to capacity with the largest value
    post_request(MODE_QUERY, '0);
    post_request(MODE_RM, 32'sh7FFF_FFFF);
    post_request(MODE_NOP, 32'sh8000_0000);
    for (int i = 0; i < LIST_DEPTH; i++) post_request(MODE_INS, 32'sh7FFF_FFFF);
    post_request(MODE_INS, -1);
    post_request(MODE_QUERY, -1);
    post_request(MODE_RM, '0);
    post_request(MODE_RM, 32'sh7FFF_FFFF);
    post_request(MODE_INS, 32'sh8000_0000);
    post_request(MODE_QUERY, '0);

    // random phases, each under its own capacity, list kept across phases
    for (int ph = 0; ph < 12; ph++) begin
      write_capacity(caps[ph]);
      style = $urandom_range(0, 2);
      for (int k = 0; k < 6; k++) pool[k] = pool_value(style);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll  = $urandom_range(0, 99);
        mode  = (roll < 40) ? MODE_INS : (roll < 70) ? MODE_RM :
                (roll < 93) ? MODE_QUERY : MODE_NOP;
        value = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 5)];
        post_request(mode, value);
        // sender pauses until the list has answered everything
        if (ph == 6 && n == PHASE_ITEMS / 2) wait_idle();
      end
      // receiver holds off while requests keep coming
      if (ph == 3) holds_asked++;
    end

    wait_idle();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
hdl/vlms_pkg.sv
hdl/vlms_seq.sv
hdl/vlms_dp.sv
hdl/value_list_with_max_run_sum.sv
tb/value_list_with_max_run_sum_test.sv
